[rtl/pcot_pkg.sv]
package pcot_pkg;

   localparam int CURRENT_BITS_DEFAULT = 16;
   localparam int ANGLE_BITS_DEFAULT   = 16;
   localparam int COUNT_BITS_DEFAULT   = 16;

   // Offsets are clamped to a 15-bit magnitude whatever the current width
   localparam int OFFSET_BITS     = 16;
   localparam int SPEED_BITS      = 16;
   localparam int MIN_SPEED_BITS  = 15;
   localparam int GAIN_BITS       = 16;
   localparam int LIMIT_BITS      = 15;
   localparam int GAIN_FRAC_BITS  = 15;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [MIN_SPEED_BITS-1:0] MIN_SPEED_RESET    = 15'd0;
   localparam logic [GAIN_BITS-1:0]      GAIN_RESET         = 16'd328;
   localparam logic [LIMIT_BITS-1:0]     OFFSET_LIMIT_RESET = 15'd1024;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_SPEED,
      CSR_GAIN,
      CSR_OFFSET_LIMIT,
      CSR_SAMPLE_LIMIT
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_CORRECT,
      OP_ACCUM,
      OP_DIV_LOAD_A,
      OP_DIV_LOAD_B,
      OP_DIV_STEP,
      OP_MUL,
      OP_SET_A,
      OP_SET_B,
      OP_REOPEN,
      OP_EMIT
   } uop_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_BEAT,
      CND_SKIP,
      CND_OVER_LIMIT,
      CND_SHORT,
      CND_DIV_BUSY,
      CND_OUT_BUSY
   } cond_type;

   typedef logic [3:0] upc_type;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      upc_type  target;
   } uword_type;

   typedef struct packed {
      logic no_beat;
      logic skip;
      logic over_limit;
      logic short_window;
      logic div_busy;
      logic out_busy;
   } flags_type;

   localparam upc_type UPC_WAIT     = 4'd0;
   localparam upc_type UPC_CORRECT  = 4'd1;
   localparam upc_type UPC_ACCUM    = 4'd2;
   localparam upc_type UPC_LIMIT    = 4'd3;
   localparam upc_type UPC_TURN     = 4'd4;
   localparam upc_type UPC_LOAD_A   = 4'd5;
   localparam upc_type UPC_DIV_A    = 4'd6;
   localparam upc_type UPC_MUL_A    = 4'd7;
   localparam upc_type UPC_SET_A    = 4'd8;
   localparam upc_type UPC_LOAD_B   = 4'd9;
   localparam upc_type UPC_DIV_B    = 4'd10;
   localparam upc_type UPC_MUL_B    = 4'd11;
   localparam upc_type UPC_SET_B    = 4'd12;
   localparam upc_type UPC_REOPEN   = 4'd13;
   localparam upc_type UPC_EMIT     = 4'd14;

   // Control store: a taken condition jumps to target, otherwise fall through
   function automatic uword_type ucode(upc_type pc);
      uword_type w;
      case (pc)
         UPC_WAIT:    w = '{op: OP_LATCH,     cond: CND_NO_BEAT,    target: UPC_WAIT};
         UPC_CORRECT: w = '{op: OP_CORRECT,   cond: CND_SKIP,       target: UPC_REOPEN};
         UPC_ACCUM:   w = '{op: OP_ACCUM,     cond: CND_NEVER,      target: UPC_WAIT};
         UPC_LIMIT:   w = '{op: OP_NOP,       cond: CND_OVER_LIMIT, target: UPC_REOPEN};
         UPC_TURN:    w = '{op: OP_NOP,       cond: CND_SHORT,      target: UPC_EMIT};
         UPC_LOAD_A:  w = '{op: OP_DIV_LOAD_A, cond: CND_NEVER,     target: UPC_WAIT};
         UPC_DIV_A:   w = '{op: OP_DIV_STEP,  cond: CND_DIV_BUSY,   target: UPC_DIV_A};
         UPC_MUL_A:   w = '{op: OP_MUL,       cond: CND_NEVER,      target: UPC_WAIT};
         UPC_SET_A:   w = '{op: OP_SET_A,     cond: CND_NEVER,      target: UPC_WAIT};
         UPC_LOAD_B:  w = '{op: OP_DIV_LOAD_B, cond: CND_NEVER,     target: UPC_WAIT};
         UPC_DIV_B:   w = '{op: OP_DIV_STEP,  cond: CND_DIV_BUSY,   target: UPC_DIV_B};
         UPC_MUL_B:   w = '{op: OP_MUL,       cond: CND_NEVER,      target: UPC_WAIT};
         UPC_SET_B:   w = '{op: OP_SET_B,     cond: CND_NEVER,      target: UPC_WAIT};
         UPC_REOPEN:  w = '{op: OP_REOPEN,    cond: CND_NEVER,      target: UPC_WAIT};
         UPC_EMIT:    w = '{op: OP_EMIT,      cond: CND_OUT_BUSY,   target: UPC_EMIT};
         default:     w = '{op: OP_NOP,       cond: CND_ALWAYS,     target: UPC_WAIT};
      endcase
      return w;
   endfunction

endpackage

[rtl/pcot_divider.sv]
module pcot_divider #(
   parameter int DIVIDEND_BITS = 32,
   parameter int DIVISOR_BITS  = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     busy,
   output logic [DIVIDEND_BITS-1:0] quotient
);
   localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  den_ff;
   logic [STEP_BITS-1:0]     steps_ff, steps_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS+1:0]  diff;
   logic                     fits;

   assign busy     = (steps_ff != '0);
   assign quotient = quo_ff;

   // Restoring division, one quotient bit a cycle, dividend shifts out at the top
   always_comb begin
      trial    = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff     = {1'b0, trial} - {2'b00, den_ff};
      fits     = ~diff[DIVISOR_BITS+1];
      rem_in   = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      quo_in   = {quo_ff[DIVIDEND_BITS-2:0], fits};
      steps_in = steps_ff - STEP_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else if (start) begin
         steps_ff <= STEP_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

[rtl/pcot_sequencer.sv]
module pcot_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  pcot_pkg::flags_type flags,
   output pcot_pkg::uword_type uword
);
   import pcot_pkg::*;

   upc_type pc_ff, pc_in;
   logic    taken;

   assign uword = ucode(pc_ff);

   always_comb begin
      case (uword.cond)
         CND_NEVER:      taken = 1'b0;
         CND_ALWAYS:     taken = 1'b1;
         CND_NO_BEAT:    taken = flags.no_beat;
         CND_SKIP:       taken = flags.skip;
         CND_OVER_LIMIT: taken = flags.over_limit;
         CND_SHORT:      taken = flags.short_window;
         CND_DIV_BUSY:   taken = flags.div_busy;
         CND_OUT_BUSY:   taken = flags.out_busy;
         default:        taken = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = taken ? uword.target : upc_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UPC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[rtl/phase_current_offset_tracker.sv]
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  action, current_a/b, angle, speed, settled
// rsp      out        rsp_valid/rsp_stall  corrected_a/b, estimate_a/b, window_closed
// csr      in         csr_write            csr_index, csr_data
//
// One beat at a time runs through a microcoded sequencer. A beat that closes the window
// runs the shared serial divider once for each window mean. Synchronous reset clears
// offsets, window and registers to their reset values. A finished result waits in the
// rsp register under stall while the next req beat is taken; the emit step holds until
// that result has left.
module phase_current_offset_tracker #(
   parameter int CURRENT_BITS = pcot_pkg::CURRENT_BITS_DEFAULT,
   parameter int ANGLE_BITS   = pcot_pkg::ANGLE_BITS_DEFAULT,
   parameter int COUNT_BITS   = pcot_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic signed [CURRENT_BITS-1:0]        req_current_a,
   input  logic signed [CURRENT_BITS-1:0]        req_current_b,
   input  logic [ANGLE_BITS-1:0]                 req_angle,
   input  logic signed [pcot_pkg::SPEED_BITS-1:0] req_speed,
   input  logic                                  req_settled,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [CURRENT_BITS-1:0]        rsp_corrected_a,
   output logic signed [CURRENT_BITS-1:0]        rsp_corrected_b,
   output logic signed [CURRENT_BITS-1:0]        rsp_estimate_a,
   output logic signed [CURRENT_BITS-1:0]        rsp_estimate_b,
   output logic                                  rsp_window_closed,
   input  logic                                  csr_write,
   input  logic [pcot_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [((COUNT_BITS > 16) ? COUNT_BITS : 16)-1:0] csr_data
);
   import pcot_pkg::*;

   localparam int WIDE_BITS   = (CURRENT_BITS > OFFSET_BITS) ? CURRENT_BITS : OFFSET_BITS;
   localparam int DIFF_BITS   = WIDE_BITS + 1;
   localparam int SUM_BITS    = CURRENT_BITS + COUNT_BITS;
   localparam int SWEPT_BITS  = ANGLE_BITS + 2;
   localparam int CNT_BITS    = COUNT_BITS + 1;
   localparam int PROD_BITS   = CURRENT_BITS + GAIN_BITS;
   localparam int MAG_BITS    = PROD_BITS - GAIN_FRAC_BITS;
   localparam int ADJ_BITS    = (CURRENT_BITS + 2 > 18) ? CURRENT_BITS + 2 : 18;

   localparam logic signed [DIFF_BITS-1:0] CUR_MAX =
      DIFF_BITS'((1 <<< (CURRENT_BITS - 1)) - 1);
   localparam logic signed [DIFF_BITS-1:0] CUR_MIN = -DIFF_BITS'(1 <<< (CURRENT_BITS - 1));
   localparam logic signed [SWEPT_BITS-1:0] HALF_TURN = SWEPT_BITS'(1) << (ANGLE_BITS - 1);
   localparam logic signed [SWEPT_BITS-1:0] FULL_TURN = SWEPT_BITS'(1) << ANGLE_BITS;
   localparam logic [COUNT_BITS-1:0] SAMPLE_LIMIT_RESET = '1;

   // configuration
   logic [MIN_SPEED_BITS-1:0] min_speed_ff;
   logic [GAIN_BITS-1:0]      gain_ff;
   logic [LIMIT_BITS-1:0]     offset_limit_ff;
   logic [COUNT_BITS-1:0]     sample_limit_ff;

   // latched beat
   logic                          action_ff, settled_ff;
   logic signed [CURRENT_BITS-1:0] cur_a_ff, cur_b_ff;
   logic [ANGLE_BITS-1:0]         angle_ff;
   logic signed [SPEED_BITS-1:0]  speed_ff;

   // window and offsets
   logic signed [CURRENT_BITS-1:0] corr_a_ff, corr_b_ff, corr_a_in, corr_b_in;
   logic signed [SUM_BITS-1:0]     sum_a_ff, sum_b_ff, sum_a_in, sum_b_in;
   logic signed [SWEPT_BITS-1:0]   swept_ff, swept_in;
   logic [ANGLE_BITS-1:0]          last_angle_ff;
   logic [CNT_BITS-1:0]            count_ff, count_in;
   logic signed [OFFSET_BITS-1:0]  offset_a_ff, offset_b_ff, offset_in;
   logic                           closed_ff;
   logic [PROD_BITS-1:0]           prod_ff, prod_in;

   // result register
   logic                           rsp_valid_ff;
   logic signed [CURRENT_BITS-1:0] rsp_corr_a_ff, rsp_corr_b_ff, rsp_est_a_ff, rsp_est_b_ff;
   logic                           rsp_closed_ff;

   logic signed [DIFF_BITS-1:0]    diff_a, diff_b;
   logic signed [SPEED_BITS:0]     speed_wide;
   logic [SPEED_BITS:0]            speed_mag;
   logic                           slow;
   logic signed [SWEPT_BITS-1:0]   ang_now, ang_last, ang_raw, ang_step;
   logic [SUM_BITS-1:0]            sum_a_mag, sum_b_mag;
   logic                           div_start, div_busy;
   logic [SUM_BITS-1:0]            div_dividend, div_quotient;
   logic [MAG_BITS-1:0]            step_mag;
   logic                           step_neg;
   logic signed [ADJ_BITS-1:0]     step_val, off_sel, adj_sum, lim;
   logic signed [WIDE_BITS-1:0]    est_a_wide, est_b_wide;
   logic                           beat_in;
   logic                           emit;

   flags_type flags;
   uword_type uword;

   function automatic logic signed [CURRENT_BITS-1:0] sat_cur(logic signed [DIFF_BITS-1:0] v);
      logic signed [CURRENT_BITS-1:0] r;
      if (v > CUR_MAX) begin
         r = CUR_MAX[CURRENT_BITS-1:0];
      end else if (v < CUR_MIN) begin
         r = CUR_MIN[CURRENT_BITS-1:0];
      end else begin
         r = v[CURRENT_BITS-1:0];
      end
      return r;
   endfunction

   pcot_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uword (uword)
   );

   pcot_divider #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (CNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign req_stall = (uword.op != OP_LATCH);
   assign beat_in   = req_valid & ~req_stall;
   assign emit      = (uword.op == OP_EMIT) & ~flags.out_busy;

   always_comb begin
      diff_a    = DIFF_BITS'(cur_a_ff) - DIFF_BITS'(offset_a_ff);
      diff_b    = DIFF_BITS'(cur_b_ff) - DIFF_BITS'(offset_b_ff);
      corr_a_in = sat_cur(diff_a);
      corr_b_in = sat_cur(diff_b);

      speed_wide = (SPEED_BITS+1)'(speed_ff);
      speed_mag  = (speed_wide < 0) ? $unsigned(-speed_wide) : $unsigned(speed_wide);
      slow       = speed_mag < (SPEED_BITS+1)'(min_speed_ff);

      // unwrap the angle step into [-half turn, +half turn]
      ang_now  = $signed(SWEPT_BITS'(angle_ff));
      ang_last = $signed(SWEPT_BITS'(last_angle_ff));
      ang_raw  = ang_now - ang_last;
      if (ang_raw > HALF_TURN) begin
         ang_step = ang_raw - FULL_TURN;
      end else if (ang_raw < -HALF_TURN) begin
         ang_step = ang_raw + FULL_TURN;
      end else begin
         ang_step = ang_raw;
      end
      swept_in = swept_ff + ang_step;
      sum_a_in = sum_a_ff + SUM_BITS'(corr_a_ff);
      sum_b_in = sum_b_ff + SUM_BITS'(corr_b_ff);
      count_in = count_ff + CNT_BITS'(1);

      sum_a_mag    = sum_a_ff[SUM_BITS-1] ? $unsigned(-sum_a_ff) : $unsigned(sum_a_ff);
      sum_b_mag    = sum_b_ff[SUM_BITS-1] ? $unsigned(-sum_b_ff) : $unsigned(sum_b_ff);
      div_start    = (uword.op == OP_DIV_LOAD_A) | (uword.op == OP_DIV_LOAD_B);
      div_dividend = (uword.op == OP_DIV_LOAD_B) ? sum_b_mag : sum_a_mag;

      // a mean of full negative scale needs one bit above the current width
      prod_in = PROD_BITS'(div_quotient[CURRENT_BITS:0]) * PROD_BITS'(gain_ff);

      // magnitudes truncate toward zero, the sum's sign comes back afterwards
      step_mag = prod_ff[PROD_BITS-1:GAIN_FRAC_BITS];
      step_neg = (uword.op == OP_SET_B) ? sum_b_ff[SUM_BITS-1] : sum_a_ff[SUM_BITS-1];
      step_val = step_neg ? -$signed(ADJ_BITS'(step_mag)) : $signed(ADJ_BITS'(step_mag));
      off_sel  = (uword.op == OP_SET_B) ? ADJ_BITS'(offset_b_ff) : ADJ_BITS'(offset_a_ff);
      adj_sum  = off_sel + step_val;
      lim      = $signed(ADJ_BITS'(offset_limit_ff));
      if (adj_sum > lim) begin
         offset_in = OFFSET_BITS'(lim);
      end else if (adj_sum < -lim) begin
         offset_in = OFFSET_BITS'(-lim);
      end else begin
         offset_in = OFFSET_BITS'(adj_sum);
      end

      est_a_wide = WIDE_BITS'(offset_a_ff);
      est_b_wide = WIDE_BITS'(offset_b_ff);
   end

   always_comb begin
      flags.no_beat      = ~req_valid;
      flags.skip         = action_ff | ~settled_ff | slow;
      flags.over_limit   = count_ff > CNT_BITS'(sample_limit_ff);
      flags.short_window = ~((swept_ff >= FULL_TURN) || (swept_ff <= -FULL_TURN));
      flags.div_busy     = div_busy;
      flags.out_busy     = rsp_valid_ff & rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_ff    <= MIN_SPEED_RESET;
         gain_ff         <= GAIN_RESET;
         offset_limit_ff <= OFFSET_LIMIT_RESET;
         sample_limit_ff <= SAMPLE_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_SPEED:    min_speed_ff    <= csr_data[MIN_SPEED_BITS-1:0];
            CSR_GAIN:         gain_ff         <= csr_data[GAIN_BITS-1:0];
            CSR_OFFSET_LIMIT: offset_limit_ff <= csr_data[LIMIT_BITS-1:0];
            CSR_SAMPLE_LIMIT: sample_limit_ff <= csr_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // payload datapath
   always_ff @(posedge clock) begin
      if (beat_in) begin
         action_ff  <= req_action;
         cur_a_ff   <= req_current_a;
         cur_b_ff   <= req_current_b;
         angle_ff   <= req_angle;
         speed_ff   <= req_speed;
         settled_ff <= req_settled;
      end
      if (uword.op == OP_CORRECT) begin
         corr_a_ff <= corr_a_in;
         corr_b_ff <= corr_b_in;
      end
      if (uword.op == OP_MUL) begin
         prod_ff <= prod_in;
      end
      if (emit) begin
         rsp_corr_a_ff <= corr_a_ff;
         rsp_corr_b_ff <= corr_b_ff;
         rsp_est_a_ff  <= est_a_wide[CURRENT_BITS-1:0];
         rsp_est_b_ff  <= est_b_wide[CURRENT_BITS-1:0];
         rsp_closed_ff <= closed_ff;
      end
   end

   // window state and offsets
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         swept_ff      <= '0;
         last_angle_ff <= '0;
         count_ff      <= '0;
         offset_a_ff   <= '0;
         offset_b_ff   <= '0;
         closed_ff     <= 1'b0;
      end else begin
         case (uword.op)
            OP_LATCH: begin
               if (beat_in) begin
                  closed_ff <= 1'b0;
               end
            end
            OP_ACCUM: begin
               sum_a_ff      <= sum_a_in;
               sum_b_ff      <= sum_b_in;
               swept_ff      <= swept_in;
               last_angle_ff <= angle_ff;
               count_ff      <= count_in;
            end
            OP_SET_A: offset_a_ff <= offset_in;
            OP_SET_B: begin
               offset_b_ff <= offset_in;
               closed_ff   <= 1'b1;
            end
            OP_REOPEN: begin
               sum_a_ff      <= '0;
               sum_b_ff      <= '0;
               swept_ff      <= '0;
               last_angle_ff <= angle_ff;
               count_ff      <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_corrected_a   = rsp_corr_a_ff;
   assign rsp_corrected_b   = rsp_corr_b_ff;
   assign rsp_estimate_a    = rsp_est_a_ff;
   assign rsp_estimate_b    = rsp_est_b_ff;
   assign rsp_window_closed = rsp_closed_ff;

   a_beat_starts_correction: assert property (@(posedge clock) disable iff (reset)
      beat_in |=> (uword.op == OP_CORRECT))
      else $error("accepted beat did not advance to correction");

   a_divider_only_in_step: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (uword.op == OP_DIV_STEP))
      else $error("divider running outside a divide step");

   a_idle_window_short: assert property (@(posedge clock) disable iff (reset)
      (uword.op == OP_LATCH) |-> !((swept_ff >= FULL_TURN) || (swept_ff <= -FULL_TURN)))
      else $error("window left open with a full turn swept");

endmodule

[bench/phase_current_offset_tracker_tb.sv]
module phase_current_offset_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcot_pkg::*;

   localparam int CB          = CURRENT_BITS_DEFAULT;
   localparam int AB          = ANGLE_BITS_DEFAULT;
   localparam longint FULL_TURN = longint'(1) << AB;
   localparam longint HALF_TURN = longint'(1) << (AB - 1);
   localparam longint CUR_MAX   = (longint'(1) << (CB - 1)) - 1;
   localparam longint CUR_MIN   = -(longint'(1) << (CB - 1));
   localparam bit ACTION_SAMPLE = 1'b0;
   localparam bit ACTION_REOPEN = 1'b1;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 217;

   typedef struct {
      bit                        action;
      logic signed [CB-1:0]      current_a;
      logic signed [CB-1:0]      current_b;
      logic [AB-1:0]             angle;
      logic signed [SPEED_BITS-1:0] speed;
      bit                        settled;
   } phase_beat_type;

   typedef struct {
      logic signed [CB-1:0] corrected_a;
      logic signed [CB-1:0] corrected_b;
      logic signed [CB-1:0] estimate_a;
      logic signed [CB-1:0] estimate_b;
      logic                 window_closed;
   } correction_type;

   class offset_estimate_checker;
      longint min_speed, gain, offset_limit, sample_limit;
      longint sum_a, sum_b, swept, sample_count, offset_a, offset_b;
      logic [AB-1:0] last_angle;
      correction_type due_outputs[$];
      int mismatches, outputs_checked, windows_closed, reopen_actions;

      function new();
         min_speed    = MIN_SPEED_RESET;
         gain         = GAIN_RESET;
         offset_limit = OFFSET_LIMIT_RESET;
         sample_limit = 65535;
         offset_a     = 0;
         offset_b     = 0;
         open_window(0);
      endfunction

      function void open_window(logic [AB-1:0] at_angle);
         sum_a        = 0;
         sum_b        = 0;
         swept        = 0;
         sample_count = 0;
         last_angle   = at_angle;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_MIN_SPEED:    min_speed    = value[14:0];
            CSR_GAIN:         gain         = value;
            CSR_OFFSET_LIMIT: offset_limit = value[14:0];
            CSR_SAMPLE_LIMIT: sample_limit = value;
            default: ;
         endcase
      endfunction

      function longint saturate_current(longint v);
         if (v > CUR_MAX) return CUR_MAX;
         if (v < CUR_MIN) return CUR_MIN;
         return v;
      endfunction

      // Move an offset by gain times the truncated window mean, then clamp
      function longint nudge_offset(longint offset, longint sum);
         longint mean, delta, moved;
         mean  = sum / sample_count;
         delta = (gain * mean) / 32768;
         moved = offset + delta;
         if (moved > offset_limit) moved = offset_limit;
         if (moved < -offset_limit) moved = -offset_limit;
         return moved;
      endfunction

      function void note_sample(phase_beat_type b);
         longint corr_a, corr_b, spd_mag, d;
         correction_type r;
         corr_a = saturate_current(longint'(b.current_a) - offset_a);
         corr_b = saturate_current(longint'(b.current_b) - offset_b);
         spd_mag = longint'(b.speed);
         if (spd_mag < 0) spd_mag = -spd_mag;
         r.window_closed = 1'b0;
         if (b.action == ACTION_REOPEN) begin
            reopen_actions++;
            open_window(b.angle);
         end else if (!b.settled || spd_mag < min_speed) begin
            open_window(b.angle);
         end else begin
            d = longint'(b.angle) - longint'(last_angle);
            if (d > HALF_TURN) d -= FULL_TURN;
            if (d < -HALF_TURN) d += FULL_TURN;
            last_angle = b.angle;
            swept += d;
            sum_a += corr_a;
            sum_b += corr_b;
            sample_count++;
            if (sample_count > sample_limit) begin
               open_window(b.angle);
            end else if (swept >= FULL_TURN || swept <= -FULL_TURN) begin
               offset_a = nudge_offset(offset_a, sum_a);
               offset_b = nudge_offset(offset_b, sum_b);
               r.window_closed = 1'b1;
               windows_closed++;
               open_window(b.angle);
            end
         end
         r.corrected_a = corr_a[CB-1:0];
         r.corrected_b = corr_b[CB-1:0];
         r.estimate_a  = offset_a[CB-1:0];
         r.estimate_b  = offset_b[CB-1:0];
         due_outputs.push_back(r);
      endfunction

      function void check_output(correction_type got);
         correction_type want;
         if (due_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected rsp beat ca %0d cb %0d ea %0d eb %0d closed %0b",
                        $realtime, got.corrected_a, got.corrected_b, got.estimate_a,
                        got.estimate_b, got.window_closed);
            return;
         end
         want = due_outputs.pop_front();
         outputs_checked++;
         if (got.corrected_a !== want.corrected_a || got.corrected_b !== want.corrected_b ||
             got.estimate_a !== want.estimate_a || got.estimate_b !== want.estimate_b ||
             got.window_closed !== want.window_closed) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: rsp beat %0d got  ca %0d cb %0d ea %0d eb %0d closed %0b",
                        $realtime, outputs_checked, got.corrected_a, got.corrected_b,
                        got.estimate_a, got.estimate_b, got.window_closed);
               $display("%0t: rsp beat %0d want ca %0d cb %0d ea %0d eb %0d closed %0b",
                        $realtime, outputs_checked, want.corrected_a, want.corrected_b,
                        want.estimate_a, want.estimate_b, want.window_closed);
            end
         end
      endfunction

      function int pending();
         return due_outputs.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_action;
   logic signed [CB-1:0]         req_current_a;
   logic signed [CB-1:0]         req_current_b;
   logic [AB-1:0]                req_angle;
   logic signed [SPEED_BITS-1:0] req_speed;
   logic                         req_settled;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [CB-1:0]         rsp_corrected_a;
   logic signed [CB-1:0]         rsp_corrected_b;
   logic signed [CB-1:0]         rsp_estimate_a;
   logic signed [CB-1:0]         rsp_estimate_b;
   logic                         rsp_window_closed;
   logic                         csr_write;
   csr_index_type                csr_index;
   logic [15:0]                  csr_data;

   offset_estimate_checker sb = new();

   bit            calm;
   int            speed_floor;
   int            bias_a, bias_b;
   int            run_left, run_step;
   int            settings_applied;
   logic [AB-1:0] track_angle;

   phase_current_offset_tracker DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_current_a     (req_current_a),
      .req_current_b     (req_current_b),
      .req_angle         (req_angle),
      .req_speed         (req_speed),
      .req_settled       (req_settled),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_corrected_a   (rsp_corrected_a),
      .rsp_corrected_b   (rsp_corrected_b),
      .rsp_estimate_a    (rsp_estimate_a),
      .rsp_estimate_b    (rsp_estimate_b),
      .rsp_window_closed (rsp_window_closed),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(60_000_000);
      $display("end of test: mismatches");
      $finish;
   end

   // Mostly short gaps, the odd long one; none at all during calm stretches
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (calm || roll < 55) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(20, 4);
      return $urandom_range(150, 30);
   endfunction

   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      correction_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.corrected_a   = rsp_corrected_a;
         got.corrected_b   = rsp_corrected_b;
         got.estimate_a    = rsp_estimate_a;
         got.estimate_b    = rsp_estimate_b;
         got.window_closed = rsp_window_closed;
         sb.check_output(got);
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic apply_settings(input int floor_speed, input int gain_q15,
                                 input int limit, input int window_cap);
      write_reg(CSR_MIN_SPEED, 16'(floor_speed));
      write_reg(CSR_GAIN, 16'(gain_q15));
      write_reg(CSR_OFFSET_LIMIT, 16'(limit));
      write_reg(CSR_SAMPLE_LIMIT, 16'(window_cap));
      speed_floor = floor_speed & 16'h7FFF;
      settings_applied++;
   endtask

   task automatic send_beat(input phase_beat_type b, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_action    <= b.action;
      req_current_a <= b.current_a;
      req_current_b <= b.current_b;
      req_angle     <= b.angle;
      req_speed     <= b.speed;
      req_settled   <= b.settled;
      do @(posedge clock); while (req_stall);
      sb.note_sample(b);
   endtask

   // Hold off the sender until every outstanding beat has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic phase_beat_type make_beat(bit action, int ca, int cb, int angle,
                                                int speed, bit settled);
      phase_beat_type b;
      b.action    = action;
      b.current_a = CB'(ca);
      b.current_b = CB'(cb);
      b.angle     = AB'(angle);
      b.speed     = SPEED_BITS'(speed);
      b.settled   = settled;
      return b;
   endfunction

   function automatic int fast_speed();
      int mag;
      mag = $urandom_range(32767, speed_floor);
      if ($urandom_range(1) == 0) return mag;
      return (mag == 32767 && $urandom_range(1)) ? -32768 : -mag;
   endfunction

   function automatic int biased_current(int bias);
      int noise;
      if ($urandom_range(9) == 0) return $urandom();
      noise = $urandom_range(4000);
      return bias + noise - 2000;
   endfunction

   // Mostly steady rotation with random content, the rest noise
   function automatic phase_beat_type next_beat();
      phase_beat_type b;
      int roll, mag, jitter;
      roll = $urandom_range(99);
      b = make_beat(ACTION_SAMPLE, biased_current(bias_a), biased_current(bias_b),
                    track_angle, fast_speed(), 1'b1);
      if (run_left == 0) begin
         run_left = $urandom_range(40, 4);
         case ($urandom_range(9))
            0:       run_step = $urandom_range(500, 1);
            1, 2:    run_step = $urandom_range(32768, 16000);
            default: run_step = $urandom_range(16000, 1500);
         endcase
         if ($urandom_range(1)) run_step = -run_step;
      end
      run_left--;
      if (roll < 6) begin
         b.action = ACTION_REOPEN;
         b.angle  = AB'($urandom());
      end else if (roll < 10) begin
         b.settled = 1'b0;
         b.angle   = AB'($urandom());
      end else if (roll < 13 && speed_floor > 0) begin
         mag = $urandom_range(speed_floor - 1, 0);
         b.speed = SPEED_BITS'($urandom_range(1) ? mag : -mag);
      end else if (roll < 16) begin
         b = make_beat(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(), $urandom(),
                       1'($urandom_range(1)));
      end else begin
         mag    = (run_step < 0 ? -run_step : run_step) / 8;
         jitter = $urandom_range(2 * mag);
         b.angle = AB'(track_angle + run_step + jitter - mag);
      end
      track_angle = b.angle;
      return b;
   endfunction

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACTION_SAMPLE;
      req_current_a = '0;
      req_current_b = '0;
      req_angle     = '0;
      req_speed     = '0;
      req_settled   = 1'b0;
      csr_write     = 1'b0;
      csr_index     = CSR_MIN_SPEED;
      csr_data      = '0;
      calm          = 1'b0;
      speed_floor   = 0;
      run_left      = 0;
      run_step      = 0;
      track_angle   = '0;
      settings_applied = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full-scale currents with unity-plus gain drive the offsets to the rails
      apply_settings(100, 16'hFFFF, 15'h7FFF, 16'hFFFF);
      send_beat(make_beat(ACTION_REOPEN, 32767, -32768, 0, 0, 1'b0), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 32767, -32768, 0, 5000, 1'b0), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 32767, -32768, 0, 99, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 32767, -32768, 32768, -32768, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 32767, -32768, 65535, 32767, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 32767, -32768, 0, 100, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, -32768, 32767, 100, -100, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 0, 0, 200, 0, 1'b0), pick_gap());
      // Backward turn through the half-turn wrap
      send_beat(make_beat(ACTION_REOPEN, 1000, -1000, 32768, 0, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 1000, -1000, 0, 2000, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 1000, -1000, 32769, -2000, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 1000, -1000, 1, 2000, 1'b1), pick_gap());
      drain();

      // One-sample windows, top speed threshold, zero clamp
      apply_settings(15'h7FFF, 0, 0, 1);
      send_beat(make_beat(ACTION_SAMPLE, 5, -5, 1000, 32767, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 5, -5, 30000, -32768, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 5, -5, 60000, 32766, 1'b1), pick_gap());
      send_beat(make_beat(ACTION_SAMPLE, 5, -5, 61000, -32767, 1'b1), pick_gap());
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: apply_settings(MIN_SPEED_RESET, GAIN_RESET, OFFSET_LIMIT_RESET, 16'hFFFF);
            1: apply_settings(15'h7FFF, 32768, 15'h7FFF, 16'hFFFF);
            2: apply_settings(500, 16'hFFFF, 300, 40);
            3: apply_settings(0, 0, 0, 1);
            4: apply_settings(1000, 16384, 15'h7FFF, 8);
            5: apply_settings(200, 4096, 100, 16'hFFFF);
            default:
               apply_settings($urandom_range(3000) | ($urandom_range(1) << 15),
                              $urandom_range(65535),
                              $urandom_range(32767) | ($urandom_range(1) << 15),
                              $urandom_range(1) ? $urandom_range(65535, 1)
                                                : $urandom_range(30, 3));
         endcase
         bias_a = $urandom_range(6000);
         bias_a -= 3000;
         bias_b = $urandom_range(6000);
         bias_b -= 3000;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) calm = ($urandom_range(3) == 0);
            if (p == 2 && i == PHASE_ITEMS / 2) drain();
            send_beat(next_beat(), pick_gap());
         end
         drain();
      end

      repeat (100) @(posedge clock);
      $display("%0d beats checked over %0d register settings: %0d windows closed, %0d reopens",
               sb.outputs_checked, settings_applied, sb.windows_closed, sb.reopen_actions);
      if (sb.pending() != 0)
         $display("%0d expected beats never arrived", sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatching beats", sb.mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/pcot_pkg.sv
rtl/pcot_divider.sv
rtl/pcot_sequencer.sv
rtl/phase_current_offset_tracker.sv
bench/phase_current_offset_tracker_tb.sv
